// ===== hdl/tpt_pkg.sv =====
package tpt_pkg;

    // Default sizes of the translation structures
    localparam int DEF_TLB_SETS     = 1024;
    localparam int DEF_TLB_WAYS     = 4;
    localparam int DEF_PAGE_ENTRIES = 262144;

    // Address and entry field widths
    localparam int VA_W    = 24;
    localparam int OFF_W   = 6;
    localparam int PAGE_W  = 18;
    localparam int IDX_W   = 10;
    localparam int TAG_W   = 8;
    localparam int FRAME_W = 10;
    localparam int PA_W    = 16;

    // One TLB way: {valid, tag, frame}
    localparam int ENT_W = 1 + TAG_W + FRAME_W;
    // One page table entry: {valid, frame}
    localparam int PTE_W = 1 + FRAME_W;

    // Widest way number over the supported way counts
    localparam int WAY_W_MAX = 2;

    // Stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // Command codes
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_INSTALL   = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_TLB_HIT = 2'd0;
    localparam logic [1:0] ST_PT_HIT  = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_INSTALL = 2'd3;

    // Result of one pass over the ways of a set
    typedef struct packed {
        logic                 done;
        logic                 hit;
        logic [WAY_W_MAX-1:0] hit_way;
        logic                 free;
        logic [WAY_W_MAX-1:0] free_way;
    } t_scan_res;

endpackage

// ===== hdl/tpt_mod_reduce.sv =====
module tpt_mod_reduce #(
    parameter int VW      = 10,
    parameter int MODULUS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_value,
    output logic          o_busy,
    output logic [VW-1:0] o_rem
);
    import tpt_pkg::*;

    localparam int MW = $clog2(MODULUS + 1);
    localparam int EW = VW + MW;
    localparam int RW = VW + 1;
    localparam int PW = VW + RW;
    localparam logic [EW-1:0] MOD_E = EW'(MODULUS);
    localparam logic [PW-1:0] MOD_P = PW'(MODULUS);
    // Scaled reciprocal rounded down: the quotient estimate is low by at most one
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << VW) / 64'(MODULUS));

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_QUOT = 2'd1;
    localparam logic [1:0] P_SUB  = 2'd2;
    localparam logic [1:0] P_FIX  = 2'd3;

    logic [1:0]    r_phase;
    logic [VW-1:0] r_v;
    logic [RW-1:0] r_q;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_qm;
    logic          w_ge;

    // Quotient estimate, its product with the modulus, and the final compare
    assign w_prod = {{RW{1'b0}}, r_v} * {{VW{1'b0}}, RECIP};
    assign w_qm   = {{VW{1'b0}}, r_q} * MOD_P;
    assign w_ge   = {{MW{1'b0}}, r_v} >= MOD_E;

    // Advance through estimate, subtract and correction, one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
        end else if (i_start) begin
            r_phase <= P_QUOT;
        end else begin
            unique case (r_phase)
                P_QUOT:  r_phase <= P_SUB;
                P_SUB:   r_phase <= P_FIX;
                P_FIX:   r_phase <= P_IDLE;
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
        end else begin
            case (r_phase)
                P_QUOT:  r_q <= w_prod[PW-1:VW];
                P_SUB:   r_v <= r_v - w_qm[VW-1:0];
                P_FIX:   if (w_ge) r_v <= r_v - MOD_E[VW-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = (r_phase != P_IDLE);
    assign o_rem  = r_v;

endmodule

// ===== hdl/tpt_way_scan.sv =====
module tpt_way_scan #(
    parameter int WAYS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [WAYS*tpt_pkg::ENT_W-1:0]   i_row_ent,
    input  logic [tpt_pkg::TAG_W-1:0]        i_tag,
    output tpt_pkg::t_scan_res               o_res
);
    import tpt_pkg::*;

    localparam int WB = $clog2(WAYS);

    logic          r_busy;
    logic          r_done;
    logic [WB-1:0] r_way;
    logic          r_hit;
    logic [WB-1:0] r_hit_way;
    logic          r_free;
    logic [WB-1:0] r_free_way;

    logic [ENT_W-1:0] w_ent;
    logic             w_valid;
    logic             w_match;

    // Shared tag compare on the way under the counter
    assign w_ent   = i_row_ent[int'(r_way)*ENT_W +: ENT_W];
    assign w_valid = w_ent[ENT_W-1];
    assign w_match = w_valid && (w_ent[FRAME_W +: TAG_W] == i_tag);

    // Step through the ways, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_way  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_way  <= '0;
        end else if (r_busy) begin
            if (w_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!w_valid && !r_free) begin
                r_free <= 1'b1;
            end
            if (r_way == WB'(WAYS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_way <= r_way + 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Keep the first matching way and the first empty way
    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            if (w_match && !r_hit) begin
                r_hit_way <= r_way;
            end
            if (!w_valid && !r_free) begin
                r_free_way <= r_way;
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.hit      = r_hit;
    assign o_res.hit_way  = WAY_W_MAX'(r_hit_way);
    assign o_res.free     = r_free;
    assign o_res.free_way = WAY_W_MAX'(r_free_way);

    // A pass ends after the last way and only then
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_way == WB'(WAYS - 1) && !i_start) |=> (!r_busy && r_done))
        else $error("way scan did not finish after the last way");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("scan done without a pass");

    a_idle_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |=> (r_busy || r_way == WB'(WAYS - 1)))
        else $error("scan stopped early");

endmodule

// ===== hdl/tpt_store.sv =====
module tpt_store #(
    parameter int TLB_SETS     = tpt_pkg::DEF_TLB_SETS,
    parameter int TLB_WAYS     = tpt_pkg::DEF_TLB_WAYS,
    parameter int PAGE_ENTRIES = tpt_pkg::DEF_PAGE_ENTRIES,
    localparam int SAW = (TLB_SETS > 1) ? $clog2(TLB_SETS) : 1,
    localparam int PAW = $clog2(PAGE_ENTRIES),
    localparam int WB  = $clog2(TLB_WAYS),
    localparam int ROW_W = TLB_WAYS * (tpt_pkg::ENT_W + WB)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    output logic                        o_clr_done,
    input  logic [SAW-1:0]              i_set_raddr,
    output logic [ROW_W-1:0]            o_set_rdata,
    input  logic                        i_set_we,
    input  logic [SAW-1:0]              i_set_waddr,
    input  logic [ROW_W-1:0]            i_set_wdata,
    input  logic [PAW-1:0]              i_pt_raddr,
    output logic [tpt_pkg::PTE_W-1:0]   o_pt_rdata,
    input  logic                        i_pt_we,
    input  logic [PAW-1:0]              i_pt_waddr,
    input  logic [tpt_pkg::PTE_W-1:0]   i_pt_wdata
);
    import tpt_pkg::*;

    localparam int ENTS_W = TLB_WAYS * ENT_W;

    // Reset row: all ways empty, recency order 0..WAYS-1
    function automatic logic [ROW_W-1:0] f_reset_row();
        logic [ROW_W-1:0] v;
        v = '0;
        for (int i = 0; i < TLB_WAYS; i++) begin
            v[ENTS_W + i*WB +: WB] = WB'(i);
        end
        return v;
    endfunction

    localparam logic [ROW_W-1:0] RESET_ROW = f_reset_row();

    logic [ROW_W-1:0] r_set_mem [TLB_SETS];
    logic [PTE_W-1:0] r_pt_mem  [PAGE_ENTRIES];
    logic [ROW_W-1:0] r_set_q;
    logic [PTE_W-1:0] r_pt_q;

    logic [PAW-1:0] r_clr;
    logic           r_clr_done;

    logic             w_set_we;
    logic [SAW-1:0]   w_set_waddr;
    logic [ROW_W-1:0] w_set_wdata;
    logic             w_pt_we;
    logic [PAW-1:0]   w_pt_waddr;
    logic [PTE_W-1:0] w_pt_wdata;

    // Sweep both memories once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            if (r_clr == PAW'(PAGE_ENTRIES - 1)) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Select clearing writes until the sweep ends
    always_comb begin
        if (!r_clr_done) begin
            w_set_we    = ({1'b0, r_clr} < (PAW + 1)'(TLB_SETS));
            w_set_waddr = r_clr[SAW-1:0];
            w_set_wdata = RESET_ROW;
            w_pt_we     = 1'b1;
            w_pt_waddr  = r_clr;
            w_pt_wdata  = '0;
        end else begin
            w_set_we    = i_set_we;
            w_set_waddr = i_set_waddr;
            w_set_wdata = i_set_wdata;
            w_pt_we     = i_pt_we;
            w_pt_waddr  = i_pt_waddr;
            w_pt_wdata  = i_pt_wdata;
        end
    end

    // TLB set memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_set_we) begin
            r_set_mem[w_set_waddr] <= w_set_wdata;
        end
        r_set_q <= r_set_mem[i_set_raddr];
    end

    // Page table memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[w_pt_waddr] <= w_pt_wdata;
        end
        r_pt_q <= r_pt_mem[i_pt_raddr];
    end

    assign o_clr_done  = r_clr_done;
    assign o_set_rdata = r_set_q;
    assign o_pt_rdata  = r_pt_q;

endmodule

// ===== hdl/tlb_page_table_translate_unit.sv =====
// Each accepted item passes in order through: forming the set and page table indexes,
// one registered memory read, a way scan that compares one way per cycle, and a
// write-back step.
// Only one item is in flight: a new item is accepted only after the last is written back,
// and a result waiting at the output holds off the next write-back.
// Reset: a clearing pass writes every page table entry and TLB set (PAGE_ENTRIES is
// 262144 by default); s_axis_tready stays low until it ends.
module tlb_page_table_translate_unit #(
    parameter int TLB_SETS     = tpt_pkg::DEF_TLB_SETS,
    parameter int TLB_WAYS     = tpt_pkg::DEF_TLB_WAYS,
    parameter int PAGE_ENTRIES = tpt_pkg::DEF_PAGE_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: virtual_address[23:0], frame_number[33:24], zero pad [39:34]
    input  logic [tpt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: cmd[0]
    input  logic [tpt_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: physical_address[15:0], fault_page[33:16], zero pad [39:34]
    output logic [tpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: status[1:0]
    output logic [tpt_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import tpt_pkg::*;

    localparam int SAW    = (TLB_SETS > 1) ? $clog2(TLB_SETS) : 1;
    localparam int PAW    = $clog2(PAGE_ENTRIES);
    localparam int WB     = $clog2(TLB_WAYS);
    localparam int ENTS_W = TLB_WAYS * ENT_W;
    localparam int ROW_W  = TLB_WAYS * (ENT_W + WB);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INDEX = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic               r_cmd;
    logic [VA_W-1:0]    r_va;
    logic [FRAME_W-1:0] r_frame_in;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic               w_accept;
    logic               w_commit;
    logic               w_clr_done;
    logic               w_set_busy;
    logic               w_pt_busy;
    logic [IDX_W-1:0]   w_set_rem;
    logic [PAGE_W-1:0]  w_pt_rem;
    logic [ROW_W-1:0]   w_row;
    logic [PTE_W-1:0]   w_pte;
    t_scan_res          w_scan;

    logic [TAG_W-1:0]   w_tag;
    logic [WB-1:0]      w_way;
    logic [ENT_W-1:0]   w_ent_sel;
    logic [FRAME_W-1:0] w_frame;
    logic [1:0]         w_status;
    logic               w_fault;
    logic [ROW_W-1:0]   w_new_row;
    logic [PA_W-1:0]    w_pa;
    logic [PAGE_W-1:0]  w_fault_page;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == S_WRITE) && (!r_out_valid || m_axis_tready);

    // Set index and page table index reducers
    tpt_mod_reduce #(
        .VW      (IDX_W),
        .MODULUS (TLB_SETS)
    ) u_set_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (s_axis_tdata[OFF_W +: IDX_W]),
        .o_busy  (w_set_busy),
        .o_rem   (w_set_rem)
    );

    tpt_mod_reduce #(
        .VW      (PAGE_W),
        .MODULUS (PAGE_ENTRIES)
    ) u_pt_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (s_axis_tdata[OFF_W +: PAGE_W]),
        .o_busy  (w_pt_busy),
        .o_rem   (w_pt_rem)
    );

    // TLB sets and page table
    tpt_store #(
        .TLB_SETS     (TLB_SETS),
        .TLB_WAYS     (TLB_WAYS),
        .PAGE_ENTRIES (PAGE_ENTRIES)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clr_done  (w_clr_done),
        .i_set_raddr (w_set_rem[SAW-1:0]),
        .o_set_rdata (w_row),
        .i_set_we    (w_commit && !w_fault),
        .i_set_waddr (w_set_rem[SAW-1:0]),
        .i_set_wdata (w_new_row),
        .i_pt_raddr  (w_pt_rem[PAW-1:0]),
        .o_pt_rdata  (w_pte),
        .i_pt_we     (w_commit && r_cmd == CMD_INSTALL),
        .i_pt_waddr  (w_pt_rem[PAW-1:0]),
        .i_pt_wdata  ({1'b1, r_frame_in})
    );

    assign w_tag = r_va[OFF_W + IDX_W +: TAG_W];

    // Way lookup over the set read from memory
    tpt_way_scan #(
        .WAYS (TLB_WAYS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_READ),
        .i_row_ent (w_row[ENTS_W-1:0]),
        .i_tag     (w_tag),
        .o_res     (w_scan)
    );

    // Pick the way to touch: hit way, else first empty, else least recent
    always_comb begin
        if (w_scan.hit) begin
            w_way = w_scan.hit_way[WB-1:0];
        end else if (w_scan.free) begin
            w_way = w_scan.free_way[WB-1:0];
        end else begin
            w_way = w_row[ENTS_W +: WB];
        end
    end

    assign w_ent_sel = w_row[int'(w_way)*ENT_W +: ENT_W];

    // Resolve the outcome of the item
    always_comb begin
        w_fault = 1'b0;
        if (r_cmd == CMD_INSTALL) begin
            w_status = ST_INSTALL;
            w_frame  = r_frame_in;
        end else if (w_scan.hit) begin
            w_status = ST_TLB_HIT;
            w_frame  = w_ent_sel[FRAME_W-1:0];
        end else if (w_pte[PTE_W-1]) begin
            w_status = ST_PT_HIT;
            w_frame  = w_pte[FRAME_W-1:0];
        end else begin
            w_status = ST_FAULT;
            w_frame  = '0;
            w_fault  = 1'b1;
        end
    end

    // Build the updated set: refresh the way and move it to most recent
    always_comb begin
        logic          seen;
        logic [WB-1:0] ord [TLB_WAYS];
        seen = 1'b0;
        for (int i = 0; i < TLB_WAYS; i++) begin
            ord[i] = w_row[ENTS_W + i*WB +: WB];
        end
        w_new_row = w_row;
        w_new_row[int'(w_way)*ENT_W +: ENT_W] = {1'b1, w_tag, w_frame};
        for (int i = 0; i < TLB_WAYS - 1; i++) begin
            seen = seen || (ord[i] == w_way);
            w_new_row[ENTS_W + i*WB +: WB] = seen ? ord[i+1] : ord[i];
        end
        w_new_row[ENTS_W + (TLB_WAYS-1)*WB +: WB] = w_way;
    end

    assign w_pa         = w_fault ? '0 : {w_frame, r_va[OFF_W-1:0]};
    assign w_fault_page = w_fault ? r_va[OFF_W +: PAGE_W] : '0;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (w_clr_done) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_INDEX;
            S_INDEX: if (!w_set_busy && !w_pt_busy) n_state = S_READ;
            S_READ:  n_state = S_SCAN;
            S_SCAN:  if (w_scan.done) n_state = S_WRITE;
            S_WRITE: if (w_commit) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= s_axis_tuser[0];
            r_va       <= s_axis_tdata[VA_W-1:0];
            r_frame_in <= s_axis_tdata[VA_W +: FRAME_W];
        end
    end

    // Output register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= {(OUT_DATA_W - PA_W - PAGE_W)'(0), w_fault_page, w_pa};
            r_out_user <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("committed item did not reach the output register");

    a_index_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_WRITE) |-> (!w_set_busy && !w_pt_busy))
        else $error("index reducer busy during lookup");

    a_fault_zero_pa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user == ST_FAULT) |-> (r_out_data[PA_W-1:0] == '0))
        else $error("page fault with nonzero physical address");

    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> w_clr_done)
        else $error("item taken before the clearing pass ended");

endmodule

// ===== tb/tlb_page_table_translate_unit_tb.sv =====
module tlb_page_table_translate_unit_tb;
    import tpt_pkg::*;

    localparam int NUM_SETS      = DEF_TLB_SETS;
    localparam int NUM_WAYS      = DEF_TLB_WAYS;
    localparam int NUM_PT_ENTRY  = DEF_PAGE_ENTRIES;
    localparam int RANDOM_ITEMS  = 550;
    localparam int DRAIN_CYCLES  = 40;
    // The clearing pass after reset writes every page table entry with no handshake
    localparam int STALL_LIMIT   = 800000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [1:0]        status;
        logic [PA_W-1:0]   phys_addr;
        logic [PAGE_W-1:0] fault_page;
    } t_xlate_result;

    // Tracks TLB and page table contents and checks each returned translation
    class xlate_scoreboard;
        bit                 way_valid [NUM_SETS][NUM_WAYS];
        bit [TAG_W-1:0]     way_tag   [NUM_SETS][NUM_WAYS];
        bit [FRAME_W-1:0]   way_frame [NUM_SETS][NUM_WAYS];
        bit [WAY_W_MAX-1:0] lru_order [NUM_SETS][NUM_WAYS];
        bit [PTE_W-1:0]     page_table [int];
        t_xlate_result      expected_xlations [$];
        int                 mismatches;

        function new();
            for (int s = 0; s < NUM_SETS; s++)
                for (int w = 0; w < NUM_WAYS; w++)
                    lru_order[s][w] = WAY_W_MAX'(w);
            mismatches = 0;
        endfunction

        function int pending();
            return expected_xlations.size();
        endfunction

        // Move a way to the most recently used slot
        function void promote_way(int s, int w);
            int pos;
            pos = 0;
            while (pos < NUM_WAYS - 1 && lru_order[s][pos] != w)
                pos++;
            for (int i = pos; i < NUM_WAYS - 1; i++)
                lru_order[s][i] = lru_order[s][i + 1];
            lru_order[s][NUM_WAYS - 1] = WAY_W_MAX'(w);
        endfunction

        function int lookup_way(int s, bit [TAG_W-1:0] t);
            for (int w = 0; w < NUM_WAYS; w++)
                if (way_valid[s][w] && way_tag[s][w] == t)
                    return w;
            return -1;
        endfunction

        // Reuse a matching way, else the lowest free way, else the LRU way
        function void refill_way(int s, bit [TAG_W-1:0] t, bit [FRAME_W-1:0] f);
            int w;
            w = lookup_way(s, t);
            if (w < 0) begin
                for (int i = NUM_WAYS - 1; i >= 0; i--)
                    if (!way_valid[s][i])
                        w = i;
                if (w < 0)
                    w = int'(lru_order[s][0]);
            end
            way_valid[s][w] = 1'b1;
            way_tag[s][w]   = t;
            way_frame[s][w] = f;
            promote_way(s, w);
        endfunction

        // Predict the translation for one accepted request item
        function void note_request(logic cmd, logic [VA_W-1:0] va, logic [FRAME_W-1:0] fr);
            bit [OFF_W-1:0]   off;
            bit [PAGE_W-1:0]  page;
            bit [TAG_W-1:0]   t;
            bit [FRAME_W-1:0] f;
            int               s;
            int               pt_idx;
            int               w;
            t_xlate_result    r;
            off    = va[OFF_W-1:0];
            page   = va[VA_W-1:OFF_W];
            s      = page[IDX_W-1:0] % NUM_SETS;
            t      = page[PAGE_W-1:IDX_W];
            pt_idx = page % NUM_PT_ENTRY;
            f      = '0;
            r.fault_page = '0;
            if (cmd == CMD_INSTALL) begin
                page_table[pt_idx] = {1'b1, fr};
                refill_way(s, t, fr);
                f = fr;
                r.status = ST_INSTALL;
            end else begin
                w = lookup_way(s, t);
                if (w >= 0) begin
                    f = way_frame[s][w];
                    promote_way(s, w);
                    r.status = ST_TLB_HIT;
                end else if (page_table.exists(pt_idx) && page_table[pt_idx][FRAME_W]) begin
                    f = page_table[pt_idx][FRAME_W-1:0];
                    refill_way(s, t, f);
                    r.status = ST_PT_HIT;
                end else begin
                    r.status = ST_FAULT;
                    r.fault_page = page;
                end
            end
            r.phys_addr = (r.status == ST_FAULT) ? '0 : {f, off};
            expected_xlations.push_back(r);
        endfunction

        // Compare one returned item against the oldest prediction
        function void check_response(logic [1:0] status, logic [PA_W-1:0] pa,
                                     logic [PAGE_W-1:0] fp);
            t_xlate_result r;
            if (expected_xlations.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d pa %h fault %h", status, pa, fp);
                return;
            end
            r = expected_xlations.pop_front();
            if (status !== r.status || pa !== r.phys_addr || fp !== r.fault_page) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected status %0d pa %h fault %h, got %0d %h %h",
                             r.status, r.phys_addr, r.fault_page, status, pa, fp);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    xlate_scoreboard sb = new();
    bit              installed_pages [int];
    int              items_sent;
    int              src_calm;
    int              snk_calm;
    int              quiet_cycles;
    int              pool_sets [3];
    bit [TAG_W-1:0]  pool_tags [8];
    int              pool_nsets;
    int              pool_ntags;

    tlb_page_table_translate_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length per item, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [VA_W-1:0] make_va(logic [TAG_W-1:0] t, logic [IDX_W-1:0] s,
                                                logic [OFF_W-1:0] off);
        return {t, s, off};
    endfunction

    function automatic logic [PAGE_W-1:0] pool_page();
        return {pool_tags[$urandom_range(0, pool_ntags - 1)],
                pool_sets[$urandom_range(0, pool_nsets - 1)][IDX_W-1:0]};
    endfunction

    // Present one request item and hold it until accepted
    task automatic send_item(logic cmd, logic [VA_W-1:0] va, logic [FRAME_W-1:0] fr);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - VA_W - FRAME_W){1'b0}}, fr, va};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (cmd == CMD_INSTALL)
            installed_pages[va[VA_W-1:OFF_W]] = 1'b1;
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted translation has returned
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Fault, install and translate again when the page is new; else just translate
    task automatic run_page_sequence(logic [PAGE_W-1:0] page);
        if (!installed_pages.exists(page)) begin
            send_item(CMD_TRANSLATE, {page, 6'($urandom)}, 10'($urandom));
            send_item(CMD_INSTALL, {page, 6'($urandom)}, 10'($urandom));
        end
        repeat ($urandom_range(1, 2))
            send_item(CMD_TRANSLATE, {page, 6'($urandom)}, 10'($urandom));
    endtask

    // Pick a few hot sets and more tags than ways so that evictions occur
    task automatic new_pool();
        pool_nsets = $urandom_range(1, 3);
        pool_ntags = $urandom_range(5, 8);
        for (int i = 0; i < 3; i++)
            pool_sets[i] = $urandom_range(0, NUM_SETS - 1);
        for (int i = 0; i < 8; i++)
            pool_tags[i] = 8'($urandom);
    endtask

    // Receive side: random stalls between result items
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        snk_calm = 0;
        @(posedge i_clk);
        forever begin
            stall = draw_wait(snk_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    // Monitor both handshakes and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (s_axis_tvalid && s_axis_tready === 1'b1)
                sb.note_request(s_axis_tuser[0], s_axis_tdata[VA_W-1:0],
                                s_axis_tdata[VA_W+FRAME_W-1:VA_W]);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_response(m_axis_tuser[1:0], m_axis_tdata[PA_W-1:0],
                                  m_axis_tdata[PA_W+PAGE_W-1:PA_W]);
            if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Main stimulus
    initial begin
        int  pick;
        bit  paused;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_rst_n       <= 1'b0;
        items_sent   = 0;
        src_calm     = 0;
        quiet_cycles = 0;
        paused       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of the address and frame fields
        send_item(CMD_TRANSLATE, make_va(8'h00, 10'h000, 6'h00), 10'h000);
        send_item(CMD_INSTALL,   make_va(8'h00, 10'h000, 6'h00), 10'h000);
        send_item(CMD_TRANSLATE, make_va(8'h00, 10'h000, 6'h3f), 10'h000);
        send_item(CMD_TRANSLATE, 24'hffffff, 10'h3ff);
        send_item(CMD_INSTALL,   24'hffffff, 10'h3ff);
        send_item(CMD_TRANSLATE, 24'hffffc0, 10'h000);
        // Reinstall of a page already cached takes the new frame in place
        send_item(CMD_INSTALL,   24'hffffc0, 10'h155);
        send_item(CMD_TRANSLATE, 24'hffffff, 10'h000);
        // Installs with no prior fault fill the rest of set 0
        send_item(CMD_INSTALL,   make_va(8'h01, 10'h000, 6'h01), 10'h001);
        send_item(CMD_INSTALL,   make_va(8'h02, 10'h000, 6'h02), 10'h002);
        send_item(CMD_INSTALL,   make_va(8'h03, 10'h000, 6'h03), 10'h003);
        send_item(CMD_TRANSLATE, make_va(8'h01, 10'h000, 6'h11), 10'h000);
        // Fifth tag evicts the LRU way; the evicted page comes back from the page table
        send_item(CMD_INSTALL,   make_va(8'h04, 10'h000, 6'h04), 10'h004);
        send_item(CMD_TRANSLATE, make_va(8'h00, 10'h000, 6'h05), 10'h000);
        send_item(CMD_TRANSLATE, make_va(8'h00, 10'h000, 6'h06), 10'h000);
        send_item(CMD_TRANSLATE, make_va(8'h02, 10'h000, 6'h07), 10'h000);
        // Alternating bit patterns; frame is ignored on translate
        send_item(CMD_TRANSLATE, make_va(8'haa, 10'h155, 6'h2a), 10'h2aa);
        send_item(CMD_INSTALL,   make_va(8'h55, 10'h2aa, 6'h15), 10'h2aa);
        send_item(CMD_TRANSLATE, make_va(8'h55, 10'h2aa, 6'h2a), 10'h155);
        send_item(CMD_TRANSLATE, make_va(8'h00, 10'h000, 6'h01), 10'h3ff);
        wait_drained();

        // Random traffic: mostly well-formed page sequences over a hot pool
        new_pool();
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent % 100 < 3)
                new_pool();
            if (!paused && items_sent >= 300) begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                run_page_sequence(pool_page());
            else if (pick < 80)
                send_item(CMD_TRANSLATE, {pool_page(), 6'($urandom)}, 10'($urandom));
            else if (pick < 90)
                send_item(CMD_INSTALL, {pool_page(), 6'($urandom)}, 10'($urandom));
            else
                send_item(1'($urandom), 24'($urandom), 10'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding translations, then allow for a stray late item
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
